// ===== rtl/overwrite_task_mailbox_defines.svh =====
// Assertion macros for the task mailbox.
`ifndef OVERWRITE_TASK_MAILBOX_DEFINES_SVH
`define OVERWRITE_TASK_MAILBOX_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define OTM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("overwrite_task_mailbox: assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define OTM_ASSERT_NEXT(label, ante, cons) \
    `OTM_ASSERT(label, (ante) |=> (cons))

`else

`define OTM_ASSERT(label, prop)
`define OTM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/otm_pkg.sv =====
`timescale 1ns / 1ps

package otm_pkg;

    localparam int NUM_TASKS = 8;
    localparam int CAPACITY  = 8;
    localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int BYTES     = DATA_W / 8;

    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_POST = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Keep the low n bytes of a word, zero the rest.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < BYTES; b++)
        begin
            mask[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

// ===== rtl/overwrite_task_mailbox.sv =====
`timescale 1ns / 1ps
`include "overwrite_task_mailbox_defines.svh"

// Channel   Signals                                   Direction  Transfer when
// request   kind task_req msg_length msg_data         in         in_valid && in_ready
//           buffer_room target_dormant target_blocked
// result    ok read_length read_data wake             out        out_valid && out_ready
//
// On transfer a request issues the read of the word and length memories; once the
// result register is free, the working stage modifies and writes back the entry and
// loads the result register. A new request is taken only once the working stage is
// empty, never while the last one is still in it. Reset clears the per-task
// valid bits at once, so every mailbox reads as empty with no clearing pass. A stalled
// result holds in the output register; the working stage holds and input transfers pause.

module overwrite_task_mailbox
    import otm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        task_req,
    input  logic [7:0]        msg_length,
    input  logic [DATA_W-1:0] msg_data,
    input  logic [7:0]        buffer_room,
    input  logic              target_dormant,
    input  logic              target_blocked,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [3:0]        read_length,
    output logic [DATA_W-1:0] read_data,
    output logic              wake
);

    // Storage: message words (undefined until written) and lengths.
    logic [DATA_W-1:0] word_mem [NUM_TASKS];
    logic [LEN_W-1:0]  len_mem  [NUM_TASKS];
    // A length entry that was never written reads as empty.
    logic [NUM_TASKS-1:0] len_valid_reg;
    logic [NUM_TASKS-1:0] len_valid_next;

    // Working stage: request captured at transfer, memory read data.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [1:0]        s1_kind_reg;
    logic [TASK_W-1:0] s1_idx_reg;
    logic              s1_task_ok_reg;
    logic              s1_len_ok_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [7:0]        s1_room_reg;
    logic              s1_nowake_reg;
    logic [DATA_W-1:0] rd_word_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_valid_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok_reg;
    logic [3:0]        read_length_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              wake_reg;

    logic              in_xfer;
    logic              s1_fire;
    logic [TASK_W-1:0] in_idx;
    logic              in_task_ok;
    logic              in_len_ok;

    // Modify step results.
    logic [LEN_W-1:0]  cur_len;
    logic              is_write;
    logic              is_read;
    logic              wr_ok;
    logic              rd_ok;
    logic              mem_we;
    logic [LEN_W-1:0]  mem_len_wr;
    logic              res_ok;
    logic [3:0]        res_len;
    logic [DATA_W-1:0] res_data;
    logic              res_wake;

    // Accept a request only while the working stage is empty.
    assign in_ready   = !s1_valid_reg;
    assign in_xfer    = in_valid && in_ready;
    // Retire the working stage when the result register is free.
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || out_ready);

    assign in_idx     = task_req[TASK_W-1:0];
    assign in_task_ok = (task_req < 8'(NUM_TASKS));
    assign in_len_ok  = (msg_length != 8'd0) && (msg_length <= 8'(CAPACITY));

    // Decide the operation against the entry read back from memory.
    always_comb
    begin
        cur_len  = rd_valid_reg ? rd_len_reg : '0;
        is_write = (s1_kind_reg == KIND_SEND) || (s1_kind_reg == KIND_POST);
        is_read  = (s1_kind_reg == KIND_READ);
        wr_ok    = s1_task_ok_reg && is_write && s1_len_ok_reg;
        rd_ok    = s1_task_ok_reg && is_read && (cur_len != '0)
                   && ({4'd0, cur_len} <= s1_room_reg);

        mem_we     = s1_fire && (wr_ok || rd_ok);
        // A delivered read empties the mailbox.
        mem_len_wr = wr_ok ? s1_len_reg : '0;

        res_ok   = wr_ok || rd_ok;
        res_len  = rd_ok ? 4'(cur_len) : 4'd0;
        res_data = rd_ok ? (rd_word_reg & byte_mask(cur_len)) : '0;
        res_wake = wr_ok && (s1_kind_reg == KIND_SEND) && !s1_nowake_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        len_valid_next = len_valid_reg;
        if (mem_we)
        begin
            len_valid_next[s1_idx_reg] = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            len_valid_reg <= len_valid_next;
        end
    end

    // Capture the request and issue the memory read at transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_kind_reg    <= kind;
            s1_idx_reg     <= in_idx;
            s1_task_ok_reg <= in_task_ok;
            s1_len_ok_reg  <= in_len_ok;
            s1_len_reg     <= msg_length[LEN_W-1:0];
            s1_data_reg    <= msg_data & byte_mask(msg_length[LEN_W-1:0]);
            s1_room_reg    <= buffer_room;
            s1_nowake_reg  <= target_dormant || target_blocked;
            rd_word_reg    <= word_mem[in_idx];
            rd_len_reg     <= len_mem[in_idx];
            rd_valid_reg   <= len_valid_reg[in_idx];
        end
    end

    // Write back the modified entry; a read leaves the word as it is.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            len_mem[s1_idx_reg] <= mem_len_wr;
            if (wr_ok)
            begin
                word_mem[s1_idx_reg] <= s1_data_reg;
            end
        end
    end

    // Load the result register.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ok_reg          <= res_ok;
            read_length_reg <= res_len;
            read_data_reg   <= res_data;
            wake_reg        <= res_wake;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign read_length = read_length_reg;
    assign read_data   = read_data_reg;
    assign wake        = wake_reg;

    `OTM_ASSERT_NEXT(a_xfer_fills_stage, in_xfer, s1_valid_reg)
    `OTM_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_fire, s1_valid_reg && !in_ready)
    `OTM_ASSERT(a_wake_only_on_write,
        out_valid_reg && wake_reg |-> ok_reg && read_length_reg == 4'd0)
    `OTM_ASSERT(a_fail_is_empty,
        out_valid_reg && !ok_reg |-> read_length_reg == 4'd0 && read_data_reg == '0 && !wake_reg)
    `OTM_ASSERT_NEXT(a_read_empties, mem_we && rd_ok, len_mem[$past(s1_idx_reg)] == '0)

endmodule

// ===== verif/overwrite_task_mailbox_tb.sv =====
`timescale 1ns / 1ps

module overwrite_task_mailbox_tb;
    import otm_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 1000;
    // Requests left in the queue when idling stops for the closing stretch.
    localparam int TAIL_ITEMS      = 150;
    // Long receiver hold-off: starts after this many transfers, lasts this long.
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_CYCLES = 200000;
    // Kind code the block ignores; it still answers with an all-zero result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]        kind;
        logic [7:0]        tgt;
        logic [7:0]        len;
        logic [DATA_W-1:0] data;
        logic [7:0]        room;
        logic              dormant;
        logic              blocked;
    } mail_req_t;

    typedef struct {
        logic              ok;
        logic [3:0]        rlen;
        logic [DATA_W-1:0] rdata;
        logic              wake;
    } mail_result_t;

    // Clock, reset and every block input start at known values.
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [1:0]        kind           = '0;
    logic [7:0]        task_req       = '0;
    logic [7:0]        msg_length     = '0;
    logic [DATA_W-1:0] msg_data       = '0;
    logic [7:0]        buffer_room    = '0;
    logic              target_dormant = 1'b0;
    logic              target_blocked = 1'b0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic              ok;
    logic [3:0]        read_length;
    logic [DATA_W-1:0] read_data;
    logic              wake;

    // Shadow copy of the mailboxes, kept in step with accepted requests.
    logic [DATA_W-1:0] box_words   [NUM_TASKS];
    logic [3:0]        box_lengths [NUM_TASKS];

    mail_req_t    pending_requests [$];
    mail_result_t awaited_results  [$];
    mail_req_t    offered;

    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   accepted_count = 0;
    int   result_count   = 0;
    int   error_count    = 0;
    logic tail_phase     = 1'b0;
    logic hold_off       = 1'b0;

    overwrite_task_mailbox i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .task_req       (task_req),
        .msg_length     (msg_length),
        .msg_data       (msg_data),
        .buffer_room    (buffer_room),
        .target_dormant (target_dormant),
        .target_blocked (target_blocked),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .read_length    (read_length),
        .read_data      (read_data),
        .wake           (wake)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Zero every byte at or above byte n.
    function automatic logic [DATA_W-1:0] keep_low_bytes(logic [DATA_W-1:0] word, int n);
        logic [DATA_W-1:0] kept;
        kept = word;
        for (int b = 0; b < DATA_W / 8; b++)
        begin
            if (b >= n)
                kept[8*b +: 8] = 8'h00;
        end
        return kept;
    endfunction

    // Apply one request to the shadow mailboxes and return the result it yields.
    function automatic mail_result_t apply_request(mail_req_t r);
        mail_result_t res;
        int           slot;
        res  = '{ok: 1'b0, rlen: 4'd0, rdata: '0, wake: 1'b0};
        slot = int'(r.tgt);
        // Out-of-range task: fail for every kind, touch nothing.
        if (slot < NUM_TASKS)
        begin
            if (r.kind == KIND_SEND || r.kind == KIND_POST)
            begin
                // Only lengths 1..CAPACITY overwrite; unread mail is lost.
                if (r.len >= 1 && r.len <= CAPACITY)
                begin
                    box_words[slot]   = keep_low_bytes(r.data, int'(r.len));
                    box_lengths[slot] = r.len[3:0];
                    res.ok   = 1'b1;
                    // A post never wakes; a send wakes unless dormant or blocked.
                    res.wake = (r.kind == KIND_SEND) && !r.dormant && !r.blocked;
                end
            end
            else if (r.kind == KIND_READ)
            begin
                // Empty mailbox or too small a buffer: nothing delivered, mail stays.
                if (box_lengths[slot] != 4'd0 && box_lengths[slot] <= r.room)
                begin
                    res.ok    = 1'b1;
                    res.rlen  = box_lengths[slot];
                    res.rdata = keep_low_bytes(box_words[slot], int'(box_lengths[slot]));
                    box_lengths[slot] = 4'd0;
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: result %0d: %s", $realtime, result_count, msg);
        error_count++;
    endtask

    task automatic queue_request(input logic [1:0] k, input logic [7:0] t,
                                 input logic [7:0] n, input logic [DATA_W-1:0] d,
                                 input logic [7:0] room, input logic dorm,
                                 input logic blk);
        mail_req_t r;
        r = '{kind: k, tgt: t, len: n, data: d, room: room, dormant: dorm, blocked: blk};
        pending_requests.push_back(r);
    endtask

    // Request driver: predict on each transfer, then present the next request
    // or idle for a random burst.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(apply_request(offered));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    offered = pending_requests.pop_front();
                    kind           <= offered.kind;
                    task_req       <= offered.tgt;
                    msg_length     <= offered.len;
                    msg_data       <= offered.data;
                    buffer_room    <= offered.room;
                    target_dormant <= offered.dormant;
                    target_blocked <= offered.blocked;
                    in_valid       <= 1'b1;
                    // Keep offering during the hold-off so the block backs up.
                    if (!tail_phase && !hold_off && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 13);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            tail_phase <= (pending_requests.size() < TAIL_ITEMS);
        end
    end

    // Result receiver: ready by default, with random stall bursts, and held low
    // for the whole long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (!tail_phase && $urandom_range(0, 11) == 0)
        begin
            recv_gap = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result monitor: compare each transfer with the oldest prediction.
    always @(posedge clk)
    begin
        mail_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result with no request outstanding");
            end
            else
            begin
                want = awaited_results.pop_front();
                if (ok !== want.ok)
                    flag_mismatch($sformatf("ok %0b, predicted %0b", ok, want.ok));
                if (read_length !== want.rlen)
                    flag_mismatch($sformatf("read_length %0d, predicted %0d",
                                            read_length, want.rlen));
                if (read_data !== want.rdata)
                    flag_mismatch($sformatf("read_data %h, predicted %h",
                                            read_data, want.rdata));
                if (wake !== want.wake)
                    flag_mismatch($sformatf("wake %0b, predicted %0b", wake, want.wake));
            end
            result_count++;
        end
    end

    // Long hold-off: stall the receiver while the sender keeps going, so the
    // output register fills and the input side has to stall.
    initial
    begin
        while (accepted_count < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("overwrite_task_mailbox test failed");
        $finish;
    end

    initial
    begin
        int                counted;
        int                pick;
        logic [1:0]        k;
        logic [7:0]        t;
        logic [7:0]        n;
        logic [7:0]        room;
        logic [7:0]        last_tgt;
        logic [DATA_W-1:0] ones;

        ones = '1;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            box_words[i]   = '0;
            box_lengths[i] = '0;
        end

        // Directed opening: empty read, full-width send with wake, buffer one
        // byte short, exact fit, read after delivery.
        queue_request(KIND_READ, 8'd0, 8'd0, '0, 8'd255, 1'b0, 1'b0);
        queue_request(KIND_SEND, 8'd0, 8'd8, ones, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd0, 8'd0, '0, 8'd7, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd0, 8'd0, '0, 8'd8, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd0, 8'd0, ones, 8'd255, 1'b1, 1'b1);
        // Last task: silent post, then sends with each wake-suppressing flag,
        // each one overwriting unread mail.
        queue_request(KIND_POST, 8'd7, 8'd1, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_SEND, 8'd7, 8'd3, ones, 8'd0, 1'b1, 1'b0);
        queue_request(KIND_SEND, 8'd7, 8'd5, 64'h0123_4567_89AB_CDEF, 8'd0, 1'b0, 1'b1);
        queue_request(KIND_SEND, 8'd7, 8'd8, 64'hFEDC_BA98_7654_3210, 8'd0, 1'b1, 1'b1);
        queue_request(KIND_READ, 8'd7, 8'd0, '0, 8'd255, 1'b0, 1'b0);
        // Invalid task numbers for each kind.
        queue_request(KIND_SEND, 8'(NUM_TASKS), 8'd4, ones, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_POST, 8'd255, 8'd4, ones, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd255, 8'd0, '0, 8'd255, 1'b0, 1'b0);
        // Invalid lengths: zero, one past capacity, maximum.
        queue_request(KIND_POST, 8'd3, 8'd0, ones, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_SEND, 8'd3, 8'(CAPACITY + 1), ones, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_POST, 8'd3, 8'd255, ones, 8'd255, 1'b1, 1'b1);
        // Unused kind, then a post whose wake flags must not matter.
        queue_request(KIND_UNUSED, 8'd3, 8'd4, ones, 8'd255, 1'b1, 1'b1);
        queue_request(KIND_POST, 8'd3, 8'd2, ones, 8'd0, 1'b1, 1'b1);
        queue_request(KIND_READ, 8'd3, 8'd0, '0, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd3, 8'd0, '0, 8'd2, 1'b0, 1'b0);
        // Back-to-back overwrite then read on one task.
        queue_request(KIND_SEND, 8'd5, 8'd4, 64'h1111_2222_3333_4444, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_POST, 8'd5, 8'd6, 64'h5555_6666_7777_8888, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd5, 8'd0, '0, 8'd6, 1'b0, 1'b0);
        queue_request(KIND_SEND, 8'd1, 8'd1, '0, 8'd0, 1'b0, 1'b0);
        queue_request(KIND_READ, 8'd1, 8'd0, '0, 8'd1, 1'b0, 1'b0);

        // Random part: mostly valid tasks and lengths, often repeating the
        // last task to hit back-to-back accesses; the rest is out-of-range noise.
        counted  = 0;
        last_tgt = 8'd0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                k = KIND_SEND;
            else if (pick < 60)
                k = KIND_POST;
            else if (pick < 95)
                k = KIND_READ;
            else
                k = KIND_UNUSED;

            pick = $urandom_range(0, 99);
            if (pick < 30)
                t = last_tgt;
            else if (pick < 88)
                t = 8'($urandom_range(0, NUM_TASKS - 1));
            else
                t = 8'($urandom_range(NUM_TASKS, 255));
            last_tgt = t;

            pick = $urandom_range(0, 99);
            if (pick < 88)
                n = 8'($urandom_range(1, CAPACITY));
            else if (pick < 92)
                n = 8'd0;
            else
                n = 8'($urandom_range(CAPACITY + 1, 255));

            if ($urandom_range(0, 99) < 30)
                room = 8'($urandom_range(0, 255));
            else
                room = 8'($urandom_range(0, CAPACITY));

            queue_request(k, t, n, {$urandom(), $urandom()}, room,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            // Ignored requests do not count toward the random total.
            if (k != KIND_UNUSED)
                counted++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has transferred and every result arrived,
        // then wait out the drain stretch to catch stray results.
        while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("overwrite_task_mailbox test passed");
        else
            $display("overwrite_task_mailbox test failed");
        $finish;
    end

endmodule
